// File: hw/rtl/paw_osc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the multi-waveform phase-accumulator oscillator.
// Also holds the elaboration-time quarter-sine generator used by the sine ROM.
// No dependencies.
package paw_osc_pkg;

    localparam int MODE_W   = 2;
    localparam int FREQ_W   = 24;
    localparam int SR_W     = 18;
    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 15;

    localparam logic [SR_W-1:0]            SR_RESET   = 18'd48000;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic [63:0]                HALF_PI_Q60 = 64'h1921FB54442D1846;

    typedef enum logic [MODE_W-1:0] {
        MODE_SINE   = 2'd0,
        MODE_SQUARE = 2'd1,
        MODE_SAW    = 2'd2,
        MODE_TRI    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // (a*b) >> 60, truncated to 64 bits
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return p[123:60];
    endfunction

    // round(32767*sin(pi/2*k/2^abits)), Taylor series in Q60; elaboration only
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned k,
                                                      input int unsigned abits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        int unsigned n;
        x    = mul_q60(HALF_PI_Q60, 64'(k) << (60 - abits));
        x2   = mul_q60(x, x);
        term = x;
        sum  = x;
        for (n = 1; n <= 12; n++) begin
            term = mul_q60(term, x2) / 64'((2 * n) * (2 * n + 1));
            if (n[0])
                sum = sum - term;
            else
                sum = sum + term;
        end
        v = ((sum >> 20) * 64'd32767 + (64'd1 << 39)) >> 40;
        if (v > 64'd32767)
            v = 64'd32767;
        return v[MAG_W-1:0];
    endfunction

endpackage

// File: hw/rtl/phase_accumulator_waveform_osc_top.sv
`timescale 1ns / 1ps
// Multi-waveform numerically controlled oscillator, top level.
// Depends on paw_osc_pkg, paw_osc_div, paw_osc_sine_rom, paw_osc_wave.
//
// Usage:
//   Input channel (in_valid/in_ready, mode, frequency): each request asks for one
//   sample. mode picks sine, square, saw or triangle; frequency is in 1/256 Hz.
//   Output channel (out_valid/out_ready, sample): one signed Q1.15 sample per
//   request, taken from the phase as it stood before the request.
//   Config channel (cfg_valid/cfg_ready, cfg_data): writes sample_rate; always
//   ready, write only while no request is in flight.
// Timing:
//   After a request is accepted the phase increment is divided out one bit per
//   cycle by a serial divider over PHASE_BITS+16 dividend bits. The sample shows
//   on out_valid once the divider is done and the control has passed ST_DONE,
//   and in_ready returns at the same edge, so the next request is taken at the
//   following edge. No new request is taken while one is in flight.
// Reset: phase clears to zero, sample_rate to 48000, no sample pending.
// Stall: a finished sample waits in the output register; the next request is
//   still taken and divided, and holds in ST_DONE until the output slot frees.
module phase_accumulator_waveform_osc_top
    import paw_osc_pkg::*;
#(
    parameter int PHASE_BITS           = 32,
    parameter int SINE_TABLE_ADDR_BITS = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [MODE_W-1:0]           mode,
    input  logic [FREQ_W-1:0]           frequency,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [SAMPLE_W-1:0]  sample,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [SR_W-1:0]             cfg_data
);

    state_t                       state_reg, state_next;
    logic [PHASE_BITS-1:0]        phase_reg, phase_next;
    logic [SR_W-1:0]              rate_reg, rate_next;
    mode_t                        mode_reg, mode_next;
    logic                         out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0]   sample_reg, sample_next;

    logic                         in_acc;
    logic                         out_free;
    logic [PHASE_BITS-1:0]        incr;
    div_status_t                  div_st;
    logic [SINE_TABLE_ADDR_BITS:0] rom_addr;
    logic [MAG_W-1:0]             rom_data;
    logic signed [SAMPLE_W-1:0]   wave_sample;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;

    // shared serial divider computes the phase increment
    paw_osc_div #(
        .PHASE_BITS (PHASE_BITS)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (in_acc),
        .frequency   (frequency),
        .sample_rate (rate_reg),
        .quotient    (incr),
        .status      (div_st)
    );

    // ROM follows phase_reg, which holds still for the whole division
    paw_osc_sine_rom #(
        .ADDR_BITS (SINE_TABLE_ADDR_BITS)
    ) u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    paw_osc_wave #(
        .PHASE_BITS (PHASE_BITS),
        .ADDR_BITS  (SINE_TABLE_ADDR_BITS)
    ) u_wave (
        .phase    (phase_reg),
        .mode     (mode_reg),
        .rom_data (rom_data),
        .rom_addr (rom_addr),
        .sample   (wave_sample)
    );

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        mode_next      = mode_reg;
        out_valid_next = out_valid_reg;
        sample_next    = sample_reg;
        rate_next      = rate_reg;

        if (cfg_valid && cfg_ready)
            rate_next = cfg_data;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    mode_next  = mode_t'(mode);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_st.done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // sample from the old phase, then advance
                if (out_free)
                begin
                    sample_next    = wave_sample;
                    out_valid_next = 1'b1;
                    phase_next     = phase_reg + incr;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            rate_reg      <= SR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            rate_reg      <= rate_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        sample_reg <= sample_next;
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

endmodule

// File: hw/rtl/paw_osc_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider: phase increment = (frequency << (PHASE_BITS-8)) / rate.
// One quotient bit per cycle through a single subtract/compare. Uses paw_osc_pkg.
module paw_osc_div
    import paw_osc_pkg::*;
#(
    parameter int PHASE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [FREQ_W-1:0]     frequency,
    input  logic [SR_W-1:0]       sample_rate,
    output logic [PHASE_BITS-1:0] quotient,
    output div_status_t           status
);

    localparam int NUM_W = FREQ_W + PHASE_BITS - 8;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]      num_reg, num_next;
    logic [SR_W-1:0]       rem_reg, rem_next;
    logic [SR_W-1:0]       den_reg, den_next;
    logic [PHASE_BITS-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [SR_W:0] trial;
    logic [SR_W:0] diff;
    logic          ge;

    // the shared unit: shift in one dividend bit, compare and subtract
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = {frequency, {(PHASE_BITS - 8){1'b0}}};
            rem_next  = '0;
            // a zero rate divides as one
            den_next  = (sample_rate == '0) ? SR_W'(1) : sample_rate;
            quo_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            rem_next = ge ? diff[SR_W-1:0] : trial[SR_W-1:0];
            quo_next = {quo_reg[PHASE_BITS-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// File: hw/rtl/paw_osc_sine_rom.sv
`timescale 1ns / 1ps
// Quarter-wave sine ROM, 2^ADDR_BITS+1 entries, registered read.
// Contents generated at elaboration by paw_osc_pkg::quarter_sine.
module paw_osc_sine_rom
    import paw_osc_pkg::*;
#(
    parameter int ADDR_BITS = 10
) (
    input  logic                 clk,
    input  logic [ADDR_BITS:0]   addr,
    output logic [MAG_W-1:0]     data
);

    localparam int DEPTH = (1 << ADDR_BITS) + 1;

    typedef logic [MAG_W-1:0] tab_t [DEPTH];

    function automatic tab_t build_tab();
        tab_t t;
        int unsigned k;
        for (k = 0; k < DEPTH; k++)
            t[k] = quarter_sine(k, ADDR_BITS);
        return t;
    endfunction

    localparam tab_t TAB = build_tab();

    logic [MAG_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        data_reg <= TAB[addr];
    end

    assign data = data_reg;

endmodule

// File: hw/rtl/paw_osc_wave.sv
`timescale 1ns / 1ps
// Waveform shaper: ROM address for sine, and the Q1.15 sample for each mode.
// Combinational. Uses paw_osc_pkg.
module paw_osc_wave
    import paw_osc_pkg::*;
#(
    parameter int PHASE_BITS = 32,
    parameter int ADDR_BITS  = 10
) (
    input  logic [PHASE_BITS-1:0]       phase,
    input  mode_t                       mode,
    input  logic [MAG_W-1:0]            rom_data,
    output logic [ADDR_BITS:0]          rom_addr,
    output logic signed [SAMPLE_W-1:0]  sample
);

    localparam logic [ADDR_BITS:0]  TAB_N = {1'b1, {ADDR_BITS{1'b0}}};
    localparam logic [PHASE_BITS-1:0] HALF = {1'b1, {(PHASE_BITS - 1){1'b0}}};

    logic [15:0]          t;
    logic [ADDR_BITS-1:0] idx;
    logic [SAMPLE_W-1:0]  mag;
    logic [SAMPLE_W-1:0]  rev;

    assign t   = phase[PHASE_BITS-1 -: 16];
    assign idx = phase[PHASE_BITS-3 -: ADDR_BITS];
    // odd quadrants run the table backwards
    assign rom_addr = phase[PHASE_BITS-2] ? (TAB_N - {1'b0, idx}) : {1'b0, idx};

    assign mag = {1'b0, rom_data};
    assign rev = 16'h8000 - t;     // 32768 - t, exact for t >= 1

    always_comb
    begin
        case (mode)
            MODE_SINE:   sample = phase[PHASE_BITS-1] ? -$signed(mag) : $signed(mag);
            MODE_SQUARE: sample = (phase <= HALF) ? SAMPLE_MAX : SAMPLE_MIN;
            MODE_SAW:    sample = (t == 16'd0) ? SAMPLE_MAX : $signed(rev);
            MODE_TRI:
            begin
                if (t[15])
                    sample = $signed({1'b0, t[14:0]});
                else if (t == 16'd0)
                    sample = SAMPLE_MAX;
                else
                    sample = $signed(rev);
            end
            default:     sample = SAMPLE_MAX;
        endcase
    end

endmodule

// File: hw/rtl/paw_osc_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the oscillator top level, with its bind.
// Depends on paw_osc_pkg and phase_accumulator_waveform_osc_top.
module paw_osc_checker
    import paw_osc_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic signed [SAMPLE_W-1:0] sample
);

    // held sample stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample))
        else $error("sample changed while stalled");

    // one request at a time: busy right after a request
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready stayed high after a request");

    // in_ready drops only because a request was taken
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid))
        else $error("in_ready fell without a request");

    // the divider needs time: no new sample right after a request
    a_no_instant_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("sample appeared one cycle after request");

endmodule

bind phase_accumulator_waveform_osc_top paw_osc_checker u_paw_osc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample    (sample)
);

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench for phase_accumulator_waveform_osc_top: checks every sample against a local model.
// Depends on paw_osc_pkg (mode codes, field widths, reset rate) and the oscillator RTL.
module tb_top;
    import paw_osc_pkg::*;

    localparam int PHASE_W      = 32;
    localparam int QTAB_BITS    = 10;
    localparam int QTAB_N       = 1 << QTAB_BITS;
    // leave margin after the last sample before config writes
    localparam int DRAIN_CYCLES = 64;
    // covers the slowest legal run of ~1070 requests
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic [63:0] PI_HALF_Q60 = 64'h1921FB54442D1846;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [MODE_W-1:0]          mode;
    logic [FREQ_W-1:0]          frequency;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [SR_W-1:0]            cfg_data;

    // model state: phase accumulator and the programmed sample rate
    logic [PHASE_W-1:0]         phase_model;
    logic [SR_W-1:0]            rate_model;
    logic [MAG_W-1:0]           sine_quarter [0:QTAB_N];

    // samples owed by the block, oldest first
    logic signed [SAMPLE_W-1:0] samples_due [$];
    int unsigned                err_count;
    int unsigned                cycle_count = 0;
    bit                         no_idle;

    phase_accumulator_waveform_osc_top #(
        .PHASE_BITS           (PHASE_W),
        .SINE_TABLE_ADDR_BITS (QTAB_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .frequency (frequency),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sample    (sample),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // hard stop if the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Q60 fixed-point product, top bits dropped as in the table generator
    function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[123:60];
    endfunction

    // quarter-wave table, round(32767*sin(pi/2*k/N)) via a 13-term Taylor series in Q60
    initial
    begin : sine_table_init
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        for (int k = 0; k <= QTAB_N; k++)
        begin
            x    = q60_mul(PI_HALF_Q60, 64'(k) << (60 - QTAB_BITS));
            x2   = q60_mul(x, x);
            term = x;
            sum  = x;
            for (int n = 1; n <= 12; n++)
            begin
                term = q60_mul(term, x2) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            v = ((sum >> 20) * 64'd32767 + (64'd1 << 39)) >> 40;
            if (v > 64'd32767)
                v = 64'd32767;
            sine_quarter[k] = v[MAG_W-1:0];
        end
    end

    // waveform value at a given phase; +1 saturates to 32767 on every shape
    function automatic logic signed [SAMPLE_W-1:0] wave_at(input mode_t m,
                                                          input logic [PHASE_W-1:0] ph);
        int t;
        int idx;
        int val;
        t = int'(ph[PHASE_W-1 -: 16]);
        case (m)
            MODE_SINE:
            begin
                // odd quadrants read the table backwards, the lower half is negated
                idx = ph[PHASE_W-2] ? QTAB_N - int'(ph[PHASE_W-3 -: QTAB_BITS])
                                    : int'(ph[PHASE_W-3 -: QTAB_BITS]);
                val = ph[PHASE_W-1] ? -int'(sine_quarter[idx]) : int'(sine_quarter[idx]);
            end
            MODE_SQUARE: val = (ph <= (32'd1 << (PHASE_W - 1))) ? 32767 : -32768;
            MODE_SAW:    val = 32768 - t;
            default:     val = (t >= 32768) ? t - 32768 : 32768 - t;
        endcase
        if (val > 32767)
            val = 32767;
        return val[SAMPLE_W-1:0];
    endfunction

    // Send one request; the expected sample is booked at the accepting edge and
    // the model phase steps by floor(f*2^24/rate), rate 0 counting as 1.
    task automatic send_request(input mode_t m, input logic [FREQ_W-1:0] f);
        int unsigned gap;
        logic [47:0] step;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= m;
        frequency <= f;
        do @(posedge clk); while (!in_ready);
        samples_due.push_back(wave_at(m, phase_model));
        step = {f, 24'd0} / 48'((rate_model == '0) ? 18'd1 : rate_model);
        phase_model = phase_model + step[PHASE_W-1:0];
    endtask

    // Drop the request line, let every owed sample arrive, then give the divider
    // time to finish before anything touches the register.
    task automatic wait_idle;
        in_valid <= 1'b0;
        while (samples_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_rate(input logic [SR_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        rate_model = value;
    endtask

    // Phase is zero out of reset and frequency 0 keeps it there: sine 0,
    // square/saw/triangle all hit +1 and must saturate.
    task automatic test_reset_waves;
        send_request(MODE_SINE, 24'd0);
        send_request(MODE_SQUARE, 24'd0);
        send_request(MODE_SAW, 24'd0);
        send_request(MODE_TRI, 24'd0);
    endtask

    // Rate 1: the increment is frequency<<24 and mostly wraps past 2^32.
    // Walks the phase through half a cycle and the quadrant edges.
    task automatic test_large_increment;
        write_rate(18'd1);
        send_request(MODE_SQUARE, 24'd128);      // to exactly half a cycle
        send_request(MODE_SQUARE, 24'd256);      // at half: still high; step of 2^32 wraps
        send_request(MODE_SAW, 24'd64);          // saw crosses zero at half
        send_request(MODE_SINE, 24'd64);         // three-quarter point
        send_request(MODE_SINE, 24'd64);         // back to zero
        send_request(MODE_SINE, 24'hFFFFFF);     // quarter point, sine peak
        send_request(MODE_TRI, 24'd1);
        send_request(MODE_SAW, 24'hFFFFFF);
    endtask

    // A rate register of zero divides as if it were one.
    task automatic test_zero_rate;
        write_rate(18'd0);
        send_request(MODE_TRI, 24'd1);
        send_request(MODE_SINE, 24'hFFFFFF);
        send_request(MODE_SQUARE, 24'd0);
        send_request(MODE_SAW, 24'd12345);
    endtask

    // Top of the rate range and the all-ones register value.
    task automatic test_rate_extremes;
        write_rate(18'd192000);
        send_request(MODE_SINE, 24'hFFFFFF);
        send_request(MODE_TRI, 24'hFFFFFF);
        send_request(MODE_SQUARE, 24'hFFFFFF);
        write_rate(18'h3FFFF);
        send_request(MODE_SAW, 24'hFFFFFF);
        send_request(MODE_SINE, 24'h800000);
        send_request(MODE_TRI, 24'd1);
        send_request(MODE_SQUARE, 24'h7FFFFF);
    endtask

    // Random modes and frequencies over a series of rates; two phases run
    // with no idling on either side.
    task automatic test_random_sweep;
        logic [SR_W-1:0]   plan [8];
        logic [FREQ_W-1:0] f;
        mode_t             m;
        plan = '{18'd48000, 18'd1, 18'd192000, 18'd44100, 18'd0, 18'h3FFFF, 18'd0, 18'd0};
        plan[6] = SR_W'($urandom_range(1, 192000));
        plan[7] = SR_W'($urandom_range(1, 2000));
        for (int p = 0; p < 8; p++)
        begin
            write_rate(plan[p]);
            no_idle = (p == 2 || p == 5);
            for (int i = 0; i < 130; i++)
            begin
                m = mode_t'($urandom_range(0, 3));
                case ($urandom_range(0, 3))
                    0:       f = FREQ_W'($urandom);
                    1:       f = FREQ_W'($urandom_range(0, 4095));
                    2:       f = ($urandom_range(0, 1) == 1) ? 24'hFFFFFF : 24'd0;
                    default: f = FREQ_W'($urandom_range(20 * 256, 20000 * 256));
                endcase
                send_request(m, f);
            end
        end
        no_idle = 1'b0;
    endtask

    // Output side: either ready ahead of the sample, or held off once the sample
    // shows up and only then made ready. Each accepted sample is matched
    // against the oldest one owed.
    initial
    begin : sample_checker
        int unsigned stall;
        logic signed [SAMPLE_W-1:0] want;
        out_ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 9);
            if (stall == 0)
            begin
                out_ready <= 1'b1;
                do @(posedge clk); while (!out_valid);
            end
            else
            begin
                out_ready <= 1'b0;
                do @(posedge clk); while (!out_valid);
                repeat (stall - 1) @(posedge clk);
                out_ready <= 1'b1;
                do @(posedge clk); while (!out_valid);
            end
            if (samples_due.size() == 0)
            begin
                $display("%0t: unexpected sample, expected none, got %0d", $time, sample);
                err_count++;
            end
            else
            begin
                want = samples_due.pop_front();
                if (sample !== want)
                begin
                    $display("%0t: sample mismatch, expected %0d, got %0d", $time, want, sample);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        mode        <= '0;
        frequency   <= '0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        err_count   = 0;
        no_idle     = 1'b0;
        phase_model = '0;
        rate_model  = SR_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_waves();
        test_large_increment();
        test_zero_rate();
        test_rate_extremes();
        test_random_sweep();

        wait_idle();
        if (err_count == 0 && samples_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
